// ===== rtl/core/hsv2rgb_pkg.sv =====
`default_nettype none

package hsv2rgb_pkg;

  // channel format: unsigned fraction, all ones stands for one
  localparam int CH_W = 16;
  localparam logic [CH_W-1:0] CH_ONE = 16'hFFFF;
  localparam logic [CH_W-1:0] RND_HALF = 16'h7FFF;

  // default fraction bits of the blend factor
  localparam int FRAC_BITS_DEF = 16;

  // hue sectors, one sixth of a turn each
  localparam int SEC_W = 3;
  localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

  // pixel fields carried through the front stages
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [CH_W-1:0]  val;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  alpha;
  } pix_t;

  // fields still needed for channel routing at the back end
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [CH_W-1:0]  val;
    logic [CH_W-1:0]  alpha;
  } route_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsv2rgb_sector.sv =====
`default_nettype none

module hsv2rgb_sector #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  hue,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  saturation,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  brightness,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  alpha_in,
  output logic                          out_valid,
  output hsv2rgb_pkg::pix_t             pix,
  output logic [FRAC_BITS-1:0]          factor
);

  logic [18:0]           hue6;
  logic [15:0]           rem;
  logic [FRAC_BITS+15:0] factor_wide;

  // hue * 6 as 4x + 2x
  assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
  assign rem  = hue6[15:0];
  // rescale the 16-bit remainder to FRAC_BITS fraction bits
  assign factor_wide = {rem, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pix.sector <= hue6[18:16];
    pix.val    <= brightness;
    pix.sat    <= saturation;
    pix.alpha  <= alpha_in;
    factor     <= factor_wide[FRAC_BITS+15:16];
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv2rgb_chroma.sv =====
`default_nettype none

module hsv2rgb_chroma #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  input  hsv2rgb_pkg::pix_t           pix,
  input  wire  [FRAC_BITS-1:0]        factor,
  output logic                        out_valid,
  output hsv2rgb_pkg::route_t         route,
  output logic [31:0]                 prod_p,
  output logic [31:0]                 prod_q,
  output logic [31:0]                 prod_t
);

  logic [FRAC_BITS:0]    one_minus_f;
  logic [FRAC_BITS+15:0] prod_sf;
  logic [FRAC_BITS+16:0] prod_sg;

  logic                  mid_valid;
  hsv2rgb_pkg::pix_t     mid_pix;
  logic [15:0]           sf;
  logic [15:0]           sg;

  logic [15:0]           k_p;
  logic [15:0]           k_q;
  logic [15:0]           k_t;

  // s*f and s*(1-f), both at most s
  assign one_minus_f = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, factor};
  assign prod_sf = {{FRAC_BITS{1'b0}}, pix.sat} * {16'd0, factor};
  assign prod_sg = {{(FRAC_BITS+1){1'b0}}, pix.sat} * {16'd0, one_minus_f};

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_pix <= pix;
    sf      <= prod_sf[FRAC_BITS+15:FRAC_BITS];
    sg      <= prod_sg[FRAC_BITS+15:FRAC_BITS];
  end

  // v * (1 - k) plus half an lsb, ahead of the divide by all ones
  assign k_p = hsv2rgb_pkg::CH_ONE - mid_pix.sat;
  assign k_q = hsv2rgb_pkg::CH_ONE - sf;
  assign k_t = hsv2rgb_pkg::CH_ONE - sg;

  always_ff @(posedge clk) begin
    route.sector <= mid_pix.sector;
    route.val    <= mid_pix.val;
    route.alpha  <= mid_pix.alpha;
    prod_p <= {16'd0, mid_pix.val} * {16'd0, k_p} + {16'd0, hsv2rgb_pkg::RND_HALF};
    prod_q <= {16'd0, mid_pix.val} * {16'd0, k_q} + {16'd0, hsv2rgb_pkg::RND_HALF};
    prod_t <= {16'd0, mid_pix.val} * {16'd0, k_t} + {16'd0, hsv2rgb_pkg::RND_HALF};
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv2rgb_div.sv =====
`default_nettype none

// divide by 65535: estimate (y + y>>16) >> 16, which is exact or one low,
// registered, then one compare-and-increment on the remainder
module hsv2rgb_div (
  input  wire         clk,
  input  wire  [31:0] dividend,
  output logic [15:0] quotient
);

  logic [32:0] est_sum;
  logic [16:0] q_est;
  logic [31:0] y_hold;
  logic [33:0] rem;

  assign est_sum = {1'b0, dividend} + {17'd0, dividend[31:16]};

  always_ff @(posedge clk) begin
    q_est  <= est_sum[32:16];
    y_hold <= dividend;
  end

  // rem = y - q_est * 65535
  assign rem = {2'b00, y_hold} + {17'd0, q_est} - {1'b0, q_est, 16'd0};

  always_comb begin
    if (rem >= {18'd0, hsv2rgb_pkg::CH_ONE}) begin
      quotient = q_est[15:0] + 16'd1;
    end else begin
      quotient = q_est[15:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_converter.sv =====
`default_nettype none

// hsv to rgb pixel converter, 16-bit unsigned fraction channels
//
// input: a pixel (hue, saturation, brightness, alpha_in) is taken at each
// rising edge where start is high and busy is low. busy is always low, so
// one pixel can be taken every cycle.
// output: done is high for exactly one cycle while red, green, blue and
// alpha_out hold the converted item; the receiver must take it then.
//
// throughput is one item per cycle. the five stages are: sector and blend
// factor, s*f and s*(1-f), the three v*(1-k) products, the divide-by-all-ones
// estimate, and remainder correction with channel routing.
//
// zero saturation gives p = q = t = brightness, so grey needs no special path.
// alpha rides along with the item unchanged.
//
// synchronous reset clears all valid bits; items in flight are dropped and
// done stays low until new items arrive. there is no receiver stall.
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  hue,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  saturation,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  brightness,
  input  wire  [hsv2rgb_pkg::CH_W-1:0]  alpha_in,
  output logic                          done,
  output logic [hsv2rgb_pkg::CH_W-1:0]  red,
  output logic [hsv2rgb_pkg::CH_W-1:0]  green,
  output logic [hsv2rgb_pkg::CH_W-1:0]  blue,
  output logic [hsv2rgb_pkg::CH_W-1:0]  alpha_out
);

  logic                        accept;

  // stage 1 outputs
  logic                        s1_valid;
  hsv2rgb_pkg::pix_t           s1_pix;
  logic [FRAC_BITS-1:0]        s1_factor;

  // stage 3 outputs
  logic                        s3_valid;
  hsv2rgb_pkg::route_t         s3_route;
  logic [31:0]                 s3_prod_p;
  logic [31:0]                 s3_prod_q;
  logic [31:0]                 s3_prod_t;

  // stage 4 (inside the dividers) side band
  logic                        s4_valid;
  hsv2rgb_pkg::route_t         s4_route;

  // corrected p, q, t
  logic [15:0]                 p_val;
  logic [15:0]                 q_val;
  logic [15:0]                 t_val;

  logic [15:0]                 red_next;
  logic [15:0]                 green_next;
  logic [15:0]                 blue_next;

  // every stage advances every cycle, nothing ever holds
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  hsv2rgb_sector #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha_in   (alpha_in),
    .out_valid  (s1_valid),
    .pix        (s1_pix),
    .factor     (s1_factor)
  );

  hsv2rgb_chroma #(
    .FRAC_BITS (FRAC_BITS)
  ) u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .pix       (s1_pix),
    .factor    (s1_factor),
    .out_valid (s3_valid),
    .route     (s3_route),
    .prod_p    (s3_prod_p),
    .prod_q    (s3_prod_q),
    .prod_t    (s3_prod_t)
  );

  // one divider per term, all in lockstep
  hsv2rgb_div u_div_p (
    .clk      (clk),
    .dividend (s3_prod_p),
    .quotient (p_val)
  );

  hsv2rgb_div u_div_q (
    .clk      (clk),
    .dividend (s3_prod_q),
    .quotient (q_val)
  );

  hsv2rgb_div u_div_t (
    .clk      (clk),
    .dividend (s3_prod_t),
    .quotient (t_val)
  );

  // sector and alpha follow the divider's register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_route <= s3_route;
  end

  // route v, p, q, t to the channels by sector
  always_comb begin
    unique case (s4_route.sector)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_next   = s4_route.val;
        green_next = t_val;
        blue_next  = p_val;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_next   = q_val;
        green_next = s4_route.val;
        blue_next  = p_val;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        red_next   = p_val;
        green_next = s4_route.val;
        blue_next  = t_val;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        red_next   = p_val;
        green_next = q_val;
        blue_next  = s4_route.val;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_next   = t_val;
        green_next = p_val;
        blue_next  = s4_route.val;
      end
      default: begin
        // magenta to red, the last sector
        red_next   = s4_route.val;
        green_next = p_val;
        blue_next  = q_val;
      end
    endcase
  end

  // output register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    red       <= red_next;
    green     <= green_next;
    blue      <= blue_next;
    alpha_out <= s4_route.alpha;
  end

endmodule

`default_nettype wire
